// File: rtl/core/mse_pkg.sv
// Shared opcodes, status codes and stage record for the MIPS subset execute unit.
`default_nettype none
package mse_pkg;

    localparam logic [4:0] OP_ADD  = 5'd0;
    localparam logic [4:0] OP_ADDU = 5'd1;
    localparam logic [4:0] OP_SUB  = 5'd2;
    localparam logic [4:0] OP_SUBU = 5'd3;
    localparam logic [4:0] OP_SLT  = 5'd4;
    localparam logic [4:0] OP_AND  = 5'd5;
    localparam logic [4:0] OP_OR   = 5'd6;
    localparam logic [4:0] OP_ADDI = 5'd7;
    localparam logic [4:0] OP_BEQ  = 5'd8;
    localparam logic [4:0] OP_BNE  = 5'd9;
    localparam logic [4:0] OP_J    = 5'd10;
    localparam logic [4:0] OP_LB   = 5'd11;
    localparam logic [4:0] OP_LH   = 5'd12;
    localparam logic [4:0] OP_LW   = 5'd13;
    localparam logic [4:0] OP_SB   = 5'd14;
    localparam logic [4:0] OP_SH   = 5'd15;
    localparam logic [4:0] OP_SW   = 5'd16;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_ADDR = 2'd2;

    // execute result as it travels down the pipe
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] next_pc;
        logic        wr;      // register write survives (r0 and traps removed)
        logic [4:0]  widx;
        logic [31:0] wval;    // ALU value; loads fill in at the memory stage
        logic        ld;      // load that writes a register
        logic        st;      // aligned store
        logic [31:0] ea;
    } mse_res_t;

endpackage
`default_nettype wire

// File: rtl/core/mips_subset_execute_unit.sv
// Top level of the MIPS32 integer subset execute unit.
//
// Usage: decoded instructions come in on the in_valid / in_ready channel, one
// word per instruction; each produces exactly one result word on the
// out_valid / out_ready channel (status, next_pc, register write).
// start_pc_we with start_pc loads the program counter; write it only while
// the unit is idle.
// Pipeline: operand read and execute, two stages of word index, data memory
// access and commit, then the output register. Throughput is one word per
// cycle while the output and the load interlock do not stall; an instruction
// that reads the destination of a load still in flight waits in stage 1 until
// that load commits.
// Register file: two RAM copies (one per read port), forwarded from the later
// stages and from the last committed write; entries read as zero until written.
// Reset: the program counter goes to zero and a clearing pass writes zero into
// every data memory word, one word a cycle, with in_ready low.
// A stalled receiver holds the output register; the pipe keeps accepting until
// every stage is full, then in_ready drops.
`default_nettype none
module mips_subset_execute_unit
    import mse_pkg::*;
#(
    parameter int MEM_WORDS = 1024
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start_pc_we,
    input  wire [31:0]  start_pc,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire [4:0]   req_type,
    input  wire [4:0]   src_reg,
    input  wire [4:0]   second_reg,
    input  wire [4:0]   dest_reg,
    input  wire signed [15:0] immediate,
    input  wire [25:0]  jump_target,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [1:0]  status,
    output logic [31:0] next_pc,
    output logic        reg_written,
    output logic [4:0]  written_index,
    output logic [31:0] written_value
);

    localparam int AW = $clog2(MEM_WORDS);

    // pick the youngest in-flight writer; flag a load whose data is not ready
    function automatic logic [32:0] fwd_pick(
        input logic [4:0]  idx,
        input logic [31:0] base,
        input logic        v2,
        input mse_res_t    r2,
        input logic        v3,
        input mse_res_t    r3,
        input logic        v4,
        input mse_res_t    r4
    );
        logic [32:0] pick;
        pick = {1'b0, base};
        if (v4 && r4.wr && r4.widx == idx)
        begin
            pick = {r4.ld, r4.wval};
        end
        if (v3 && r3.wr && r3.widx == idx)
        begin
            pick = {r3.ld, r3.wval};
        end
        if (v2 && r2.wr && r2.widx == idx)
        begin
            pick = {r2.ld, r2.wval};
        end
        return pick;
    endfunction

    // handshake and stage control
    logic accept;
    logic out_free;
    logic s1_adv;
    logic s2_adv;
    logic s3_adv;
    logic s4_adv;
    logic hazard;

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic s4_valid_reg, s4_valid_next;
    logic out_valid_reg, out_valid_next;

    // stage 1: operands
    logic [4:0]  s1_op_reg;
    logic [4:0]  s1_src_reg;
    logic [4:0]  s1_second_reg;
    logic [4:0]  s1_dest_reg;
    logic [15:0] s1_imm_reg;
    logic [25:0] s1_tgt_reg;
    logic [31:0] pc_reg;

    // register file
    logic [31:0] rf_vld_reg;
    logic        rs_vld_reg;
    logic        rt_vld_reg;
    logic [4:0]  rs_raddr;
    logic [4:0]  rt_raddr;
    logic [31:0] rs_ram;
    logic [31:0] rt_ram;
    logic        rf_we;
    logic [31:0] rf_wdata;
    logic        lw_v_reg;
    logic [4:0]  lw_idx_reg;
    logic [31:0] lw_val_reg;
    logic [31:0] rs_base;
    logic [31:0] rt_base;
    logic [31:0] rs_val;
    logic [31:0] rt_val;
    logic        rs_hz;
    logic        rt_hz;

    mse_res_t    ex_res;

    // stages 2 to 4
    mse_res_t    s2_res_reg, s3_res_reg, s4_res_reg;
    logic [4:0]  s2_op_reg, s3_op_reg, s4_op_reg;
    logic [31:0] s2_b_reg, s3_b_reg, s4_b_reg;
    logic [AW-1:0] s4_addr_reg;

    // data memory
    logic [AW-1:0] dm_raddr;
    logic [31:0]   dm_rdata;
    logic          dm_we;
    logic [AW-1:0] dm_waddr;
    logic [31:0]   dm_wdata;
    logic          dlw_v_reg;
    logic [AW-1:0] dlw_addr_reg;
    logic [31:0]   dlw_data_reg;
    logic [31:0]   mem_word;
    logic [7:0]    ld_byte;
    logic [15:0]   ld_half;
    logic [31:0]   ld_val;
    logic [31:0]   st_word;

    // clearing pass
    logic          clr_active_reg, clr_active_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    // output register
    logic [1:0]  status_reg;
    logic [31:0] next_pc_reg;
    logic        reg_written_reg;
    logic [4:0]  written_index_reg;
    logic [31:0] written_value_reg;

    // ---------------------------------------------------------------- control
    assign out_free = !out_valid_reg || out_ready;
    assign s4_adv   = s4_valid_reg && out_free;
    assign s3_adv   = s3_valid_reg && (!s4_valid_reg || s4_adv);
    assign s2_adv   = s2_valid_reg && (!s3_valid_reg || s3_adv);
    assign s1_adv   = s1_valid_reg && (!s2_valid_reg || s2_adv) && !hazard;
    assign in_ready = !clr_active_reg && (!s1_valid_reg || s1_adv);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        s2_valid_next  = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_reg);
        s3_valid_next  = s2_adv ? 1'b1 : (s3_adv ? 1'b0 : s3_valid_reg);
        s4_valid_next  = s3_adv ? 1'b1 : (s4_adv ? 1'b0 : s4_valid_reg);
        out_valid_next = s4_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(MEM_WORDS - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            pc_reg         <= '0;
            rf_vld_reg     <= '0;
            rs_vld_reg     <= 1'b0;
            rt_vld_reg     <= 1'b0;
            lw_v_reg       <= 1'b0;
            dlw_v_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            s2_valid_reg   <= s2_valid_next;
            s3_valid_reg   <= s3_valid_next;
            s4_valid_reg   <= s4_valid_next;
            out_valid_reg  <= out_valid_next;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            if (start_pc_we)
            begin
                pc_reg <= start_pc;
            end
            else if (s1_adv)
            begin
                pc_reg <= ex_res.next_pc;
            end
            // valid flags follow the RAM read timing
            rs_vld_reg <= rf_vld_reg[rs_raddr];
            rt_vld_reg <= rf_vld_reg[rt_raddr];
            if (rf_we)
            begin
                rf_vld_reg[s4_res_reg.widx] <= 1'b1;
                lw_v_reg <= 1'b1;
            end
            if (s4_adv && s4_res_reg.st)
            begin
                dlw_v_reg <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- stage 1
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg     <= req_type;
            s1_src_reg    <= src_reg;
            s1_second_reg <= second_reg;
            s1_dest_reg   <= dest_reg;
            s1_imm_reg    <= immediate;
            s1_tgt_reg    <= jump_target;
        end
    end

    // re-read every cycle so a held word sees all but the latest write
    assign rs_raddr = accept ? src_reg : s1_src_reg;
    assign rt_raddr = accept ? second_reg : s1_second_reg;

    mse_ram #(
        .WIDTH (32),
        .DEPTH (32)
    ) u_rf_rs (
        .clk   (clk),
        .we    (rf_we),
        .waddr (s4_res_reg.widx),
        .wdata (rf_wdata),
        .re    (1'b1),
        .raddr (rs_raddr),
        .rdata (rs_ram)
    );

    mse_ram #(
        .WIDTH (32),
        .DEPTH (32)
    ) u_rf_rt (
        .clk   (clk),
        .we    (rf_we),
        .waddr (s4_res_reg.widx),
        .wdata (rf_wdata),
        .re    (1'b1),
        .raddr (rt_raddr),
        .rdata (rt_ram)
    );

    assign rs_base = (lw_v_reg && lw_idx_reg == s1_src_reg) ? lw_val_reg :
                     (rs_vld_reg ? rs_ram : 32'd0);
    assign rt_base = (lw_v_reg && lw_idx_reg == s1_second_reg) ? lw_val_reg :
                     (rt_vld_reg ? rt_ram : 32'd0);

    assign {rs_hz, rs_val} = fwd_pick(s1_src_reg, rs_base, s2_valid_reg, s2_res_reg,
                                      s3_valid_reg, s3_res_reg, s4_valid_reg, s4_res_reg);
    assign {rt_hz, rt_val} = fwd_pick(s1_second_reg, rt_base, s2_valid_reg, s2_res_reg,
                                      s3_valid_reg, s3_res_reg, s4_valid_reg, s4_res_reg);
    assign hazard = s1_valid_reg && (rs_hz || rt_hz);

    mse_exec u_exec (
        .op     (s1_op_reg),
        .rs_val (rs_val),
        .rt_val (rt_val),
        .rt_idx (s1_second_reg),
        .rd_idx (s1_dest_reg),
        .imm    (s1_imm_reg),
        .tgt    (s1_tgt_reg),
        .pc     (pc_reg),
        .res    (ex_res)
    );

    // ---------------------------------------------------------- stages 2 to 4
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_res_reg <= ex_res;
            s2_op_reg  <= s1_op_reg;
            s2_b_reg   <= rt_val;
        end
        if (s2_adv)
        begin
            s3_res_reg <= s2_res_reg;
            s3_op_reg  <= s2_op_reg;
            s3_b_reg   <= s2_b_reg;
        end
        if (s3_adv)
        begin
            s4_res_reg  <= s3_res_reg;
            s4_op_reg   <= s3_op_reg;
            s4_b_reg    <= s3_b_reg;
            s4_addr_reg <= dm_raddr;
        end
        if (rf_we)
        begin
            lw_idx_reg <= s4_res_reg.widx;
            lw_val_reg <= rf_wdata;
        end
        if (s4_adv && s4_res_reg.st)
        begin
            dlw_addr_reg <= s4_addr_reg;
            dlw_data_reg <= st_word;
        end
    end

    mse_widx #(
        .MEM_WORDS (MEM_WORDS)
    ) u_widx (
        .clk     (clk),
        .load    (s2_adv),
        .word_in (s2_res_reg.ea[31:2]),
        .idx     (dm_raddr)
    );

    mse_ram #(
        .WIDTH (32),
        .DEPTH (MEM_WORDS)
    ) u_dmem (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .re    (s3_adv),
        .raddr (dm_raddr),
        .rdata (dm_rdata)
    );

    // the store committed on the edge of our read is not in the RAM data yet
    assign mem_word = (dlw_v_reg && dlw_addr_reg == s4_addr_reg) ? dlw_data_reg : dm_rdata;
    assign ld_byte  = mem_word[{s4_res_reg.ea[1:0], 3'b000} +: 8];
    assign ld_half  = s4_res_reg.ea[1] ? mem_word[31:16] : mem_word[15:0];

    always_comb
    begin
        case (s4_op_reg)
            OP_LB:   ld_val = {{24{ld_byte[7]}}, ld_byte};
            OP_LH:   ld_val = {{16{ld_half[15]}}, ld_half};
            default: ld_val = mem_word;
        endcase
        st_word = mem_word;
        case (s4_op_reg)
            OP_SB:
            begin
                st_word[{s4_res_reg.ea[1:0], 3'b000} +: 8] = s4_b_reg[7:0];
            end
            OP_SH:
            begin
                if (s4_res_reg.ea[1])
                begin
                    st_word[31:16] = s4_b_reg[15:0];
                end
                else
                begin
                    st_word[15:0] = s4_b_reg[15:0];
                end
            end
            default:
            begin
                st_word = s4_b_reg;
            end
        endcase
    end

    assign rf_we    = s4_adv && s4_res_reg.wr;
    assign rf_wdata = s4_res_reg.ld ? ld_val : s4_res_reg.wval;

    assign dm_we    = clr_active_reg || (s4_adv && s4_res_reg.st);
    assign dm_waddr = clr_active_reg ? clr_addr_reg : s4_addr_reg;
    assign dm_wdata = clr_active_reg ? 32'd0 : st_word;

    // ---------------------------------------------------------------- output
    always_ff @(posedge clk)
    begin
        if (s4_adv)
        begin
            status_reg        <= s4_res_reg.status;
            next_pc_reg       <= s4_res_reg.next_pc;
            reg_written_reg   <= s4_res_reg.wr;
            written_index_reg <= s4_res_reg.widx;
            written_value_reg <= rf_wdata;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign next_pc       = next_pc_reg;
    assign reg_written   = reg_written_reg;
    assign written_index = written_index_reg;
    assign written_value = written_value_reg;

    // ------------------------------------------------------------- assertions
    a_r0_never_written: assert property (@(posedge clk) disable iff (!rst_n)
        rf_we |-> s4_res_reg.widx != 5'd0)
        else $error("write to r0 reached the register file");

    a_hazard_holds: assert property (@(posedge clk) disable iff (!rst_n)
        hazard |=> s1_valid_reg && $stable(s1_op_reg) && $stable(s1_src_reg))
        else $error("interlocked word left stage 1");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> 32'(dm_raddr) < 32'(MEM_WORDS))
        else $error("data memory word index out of range");

    a_trap_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_OK |-> !reg_written_reg)
        else $error("trapped word reports a register write");

endmodule
`default_nettype wire

// File: rtl/core/mse_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire                       clk,
    input  wire                       we,
    input  wire [$clog2(DEPTH)-1:0]   waddr,
    input  wire [WIDTH-1:0]           wdata,
    input  wire                       re,
    input  wire [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-during-write returns the old contents
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: rtl/core/mse_exec.sv
// Integer ALU, branch and address generation for one instruction.
`default_nettype none
module mse_exec
    import mse_pkg::*;
(
    input  wire [4:0]  op,
    input  wire [31:0] rs_val,
    input  wire [31:0] rt_val,
    input  wire [4:0]  rt_idx,
    input  wire [4:0]  rd_idx,
    input  wire [15:0] imm,
    input  wire [25:0] tgt,
    input  wire [31:0] pc,
    output mse_res_t   res
);

    logic [31:0] imm32;
    logic [31:0] pc4;
    logic [31:0] br_pc;
    logic [31:0] ea;
    logic [31:0] bsel;
    logic [31:0] sum;
    logic [31:0] diff;
    logic        add_ovf;
    logic        sub_ovf;
    logic        lt;
    logic        wr;
    logic [4:0]  idx;
    logic [31:0] val;

    assign imm32   = {{16{imm[15]}}, imm};
    assign pc4     = pc + 32'd4;
    assign br_pc   = pc4 + {imm32[29:0], 2'b00};
    assign ea      = rs_val + imm32;
    assign bsel    = (op == OP_ADDI) ? imm32 : rt_val;
    assign sum     = rs_val + bsel;
    assign diff    = rs_val - rt_val;
    assign add_ovf = (rs_val[31] == bsel[31]) && (sum[31] != rs_val[31]);
    assign sub_ovf = (rs_val[31] != rt_val[31]) && (diff[31] != rs_val[31]);
    assign lt      = $signed(rs_val) < $signed(rt_val);

    always_comb
    begin
        res         = '0;
        res.next_pc = pc4;
        res.ea      = ea;
        wr          = 1'b0;
        idx         = rd_idx;
        val         = sum;
        case (op)
            OP_ADD, OP_ADDI:
            begin
                if (op == OP_ADDI)
                begin
                    idx = rt_idx;
                end
                if (add_ovf)
                begin
                    res.status = ST_OVF;
                end
                else
                begin
                    wr = 1'b1;
                end
            end
            OP_ADDU:
            begin
                wr = 1'b1;
            end
            OP_SUB:
            begin
                val = diff;
                if (sub_ovf)
                begin
                    res.status = ST_OVF;
                end
                else
                begin
                    wr = 1'b1;
                end
            end
            OP_SUBU:
            begin
                wr  = 1'b1;
                val = diff;
            end
            OP_SLT:
            begin
                wr  = 1'b1;
                val = {31'd0, lt};
            end
            OP_AND:
            begin
                wr  = 1'b1;
                val = rs_val & rt_val;
            end
            OP_OR:
            begin
                wr  = 1'b1;
                val = rs_val | rt_val;
            end
            OP_BEQ:
            begin
                if (rs_val == rt_val)
                begin
                    res.next_pc = br_pc;
                end
            end
            OP_BNE:
            begin
                if (rs_val != rt_val)
                begin
                    res.next_pc = br_pc;
                end
            end
            OP_J:
            begin
                res.next_pc = {pc4[31:28], tgt, 2'b00};
            end
            OP_LB:
            begin
                wr  = 1'b1;
                idx = rt_idx;
            end
            OP_LH:
            begin
                idx = rt_idx;
                if (ea[0])
                begin
                    res.status = ST_ADDR;
                end
                else
                begin
                    wr = 1'b1;
                end
            end
            OP_LW:
            begin
                idx = rt_idx;
                if (ea[1:0] != 2'b00)
                begin
                    res.status = ST_ADDR;
                end
                else
                begin
                    wr = 1'b1;
                end
            end
            OP_SB:
            begin
                res.st = 1'b1;
            end
            OP_SH:
            begin
                if (ea[0])
                begin
                    res.status = ST_ADDR;
                end
                else
                begin
                    res.st = 1'b1;
                end
            end
            OP_SW:
            begin
                if (ea[1:0] != 2'b00)
                begin
                    res.status = ST_ADDR;
                end
                else
                begin
                    res.st = 1'b1;
                end
            end
            default:
            begin
                wr = 1'b0;
            end
        endcase

        // r0 stays zero
        if (wr && idx == 5'd0)
        begin
            wr = 1'b0;
        end
        res.wr   = wr;
        res.widx = wr ? idx : 5'd0;
        res.wval = (wr && !(op inside {OP_LB, OP_LH, OP_LW})) ? val : 32'd0;
        res.ld   = wr && (op inside {OP_LB, OP_LH, OP_LW});
    end

endmodule
`default_nettype wire

// File: rtl/core/mse_widx.sv
// Two-stage word index: (address / 4) modulo the memory depth by reciprocal multiply.
`default_nettype none
module mse_widx #(
    parameter int MEM_WORDS = 1024
) (
    input  wire                            clk,
    input  wire                            load,
    input  wire [29:0]                     word_in,
    output logic [$clog2(MEM_WORDS)-1:0]   idx
);

    localparam int          LG      = $clog2(MEM_WORDS);
    localparam int          SH      = 30 + LG;
    localparam int          EW      = 31 - LG;
    localparam logic [63:0] RECIP64 = (64'd1 << SH) / 64'(MEM_WORDS);
    localparam logic [31:0] RECIP   = RECIP64[31:0];
    localparam logic [31:0] MW      = 32'(MEM_WORDS);

    logic [29:0]   word_reg;
    logic [61:0]   prod_reg;
    logic [EW-1:0] est;
    logic [31:0]   back;
    logic [31:0]   rem;
    logic [31:0]   rem_fix;

    // first stage: quotient estimate product
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_in;
            prod_reg <= 62'(word_in) * 62'(RECIP);
        end
    end

    // second stage: estimate is exact or one short, so one correction
    assign est     = prod_reg[SH +: EW];
    assign back    = 32'(est) * MW;
    assign rem     = 32'(word_reg) - back;
    assign rem_fix = (rem >= MW) ? rem - MW : rem;
    assign idx     = rem_fix[LG-1:0];

endmodule
`default_nettype wire
